// File: hw/rtl/key_tap_auto_repeat_unit_defines.svh
// assertion macros used by key_tap_auto_repeat_unit.sv
`ifndef KEY_TAP_AUTO_REPEAT_UNIT_DEFINES_SVH
`define KEY_TAP_AUTO_REPEAT_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define KTAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define KTAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/ktar_pkg.sv
`default_nettype none

package ktar_pkg;

  // field widths
  localparam int unsigned KeyW   = 7;
  localparam int unsigned TicksW = 32;
  localparam int unsigned CfgW   = 16;

  // stream data widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;

  // register indexes of the configuration port
  localparam logic RegInitialDelay = 1'b0;
  localparam logic RegRepeatPeriod = 1'b1;

  // register reset values
  localparam logic [CfgW-1:0] InitialDelayReset = 16'd500;
  localparam logic [CfgW-1:0] RepeatPeriodReset = 16'd100;

  // one key entry as held in the state memory
  typedef struct packed {
    logic              seen;
    logic              handled;
    logic [TicksW-1:0] deadline;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// File: hw/rtl/ktar_ram.sv
`default_nettype none

module ktar_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/key_tap_auto_repeat_unit.sv
`default_nettype none

// Per-key tap detector with typematic auto-repeat. Each input transaction names
// a key, its level, a repeat enable and the current millisecond count; exactly
// one result transaction follows, saying whether the query counts as a tap or
// a repeat. Per-key state (seen, handled, repeat deadline) lives in one
// synchronous RAM of KEY_COUNT entries: a query reads its entry in the accept
// cycle, and the compute stage then forms the answer, writes the entry back and
// loads the output register once that register is free. One query per clock is
// sustained while the result stream is not stalled, also for the same key twice
// in a row, since the written entry is forwarded past the RAM. After reset the
// RAM is cleared one entry per clock, so s_axis_tready_o stays low until the
// sweep ends; configuration writes are taken at any time but should only be
// issued while no query is in flight.
module key_tap_auto_repeat_unit #(
  parameter int unsigned KEY_COUNT = 128
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_addr_i,
  input  wire logic [ktar_pkg::CfgW-1:0]       cfg_wdata_i,
  // query stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [6:0] key_index, [7] pressed, [8] repeat_enable, [40:9] now_ticks, rest zero
  input  wire logic [ktar_pkg::InDataW-1:0]    s_axis_tdata_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [0] tapped, rest zero
  output logic      [ktar_pkg::OutDataW-1:0]   m_axis_tdata_o
);

`include "key_tap_auto_repeat_unit_defines.svh"

  localparam int unsigned AddrW = $clog2(KEY_COUNT);
  localparam int unsigned TW    = ktar_pkg::TicksW;

  // configuration registers
  logic [ktar_pkg::CfgW-1:0] init_delay_q, init_delay_d;
  logic [ktar_pkg::CfgW-1:0] rep_period_q, rep_period_d;

  // clearing sweep
  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  // input field unpacking
  logic [ktar_pkg::KeyW-1:0] in_key;
  logic                      in_pressed;
  logic                      in_rep_en;
  logic [TW-1:0]             in_now;
  logic [AddrW-1:0]          in_addr;
  logic                      in_range;
  logic                      in_accept;

  // compute stage
  logic             s1_vld_q, s1_vld_d;
  logic             s1_range_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_pressed_q;
  logic             s1_rep_en_q;
  logic [TW-1:0]    s1_now_q;
  logic             s1_adv;
  logic             s1_wr;

  // forwarding of the entry written back while the query was read,
  // kept until the query leaves the stage
  logic                fwd_vld_q, fwd_vld_d;
  ktar_pkg::entry_t    fwd_entry_q;

  // output register
  logic out_vld_q, out_vld_d;
  logic out_tap_q;
  logic out_free;

  // memory interface
  logic [ktar_pkg::EntryW-1:0] ram_rdata;
  logic [ktar_pkg::EntryW-1:0] ram_wdata;
  logic [AddrW-1:0]            ram_waddr;
  logic                        ram_we;

  // entry update
  ktar_pkg::entry_t cur_entry;
  ktar_pkg::entry_t new_entry;
  logic             new_tap;
  logic             dl_due;
  logic [TW:0]      sum_initial;
  logic [TW:0]      sum_period;
  logic [TW-1:0]    sat_initial;
  logic [TW-1:0]    sat_period;

  // field unpacking and handshake
  assign in_key     = s_axis_tdata_i[6:0];
  assign in_pressed = s_axis_tdata_i[7];
  assign in_rep_en  = s_axis_tdata_i[8];
  assign in_now     = s_axis_tdata_i[40:9];
  assign in_addr    = AddrW'(in_key);
  assign in_range   = 32'(in_key) < 32'(KEY_COUNT);

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s1_adv          = s1_vld_q && out_free;
  assign s1_wr           = s1_adv && s1_range_q;
  assign s_axis_tready_o = !clr_busy_q && (!s1_vld_q || out_free);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // configuration writes
  always_comb begin
    init_delay_d = init_delay_q;
    rep_period_d = rep_period_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        ktar_pkg::RegInitialDelay: init_delay_d = cfg_wdata_i;
        ktar_pkg::RegRepeatPeriod: rep_period_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clearing sweep after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(KEY_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // saturating deadline sums
  assign sum_initial = {1'b0, s1_now_q} + (TW + 1)'(init_delay_q);
  assign sum_period  = {1'b0, s1_now_q} + (TW + 1)'(rep_period_q);
  assign sat_initial = sum_initial[TW] ? {TW{1'b1}} : sum_initial[TW-1:0];
  assign sat_period  = sum_period[TW]  ? {TW{1'b1}} : sum_period[TW-1:0];

  // entry read-modify-write
  always_comb begin
    cur_entry = fwd_vld_q ? fwd_entry_q : ktar_pkg::entry_t'(ram_rdata);
    new_entry = cur_entry;
    new_tap   = 1'b0;
    dl_due    = (cur_entry.deadline != '0) && (cur_entry.deadline <= s1_now_q);
    if (!s1_range_q) begin
      new_tap = 1'b0;
    end else if (!cur_entry.seen) begin
      new_entry.seen     = 1'b1;
      new_entry.handled  = 1'b1;
      new_entry.deadline = '0;
      new_tap            = s1_pressed_q;
    end else if (!s1_pressed_q) begin
      new_entry.handled  = 1'b0;
      new_entry.deadline = '0;
    end else begin
      if (cur_entry.deadline == '0) begin
        new_entry.deadline = sat_initial;
      end else if (dl_due) begin
        new_entry.deadline = sat_period;
      end
      new_entry.handled = 1'b1;
      new_tap           = !cur_entry.handled || (dl_due && s1_rep_en_q);
    end
  end

  // memory write mux: sweep or write-back
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_wr;
      ram_waddr = s1_addr_q;
      ram_wdata = new_entry;
    end
  end

  // stage valids
  always_comb begin
    s1_vld_d  = s1_vld_q;
    out_vld_d = out_vld_q;
    fwd_vld_d = fwd_vld_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (s1_adv) begin
      out_vld_d = 1'b1;
      s1_vld_d  = 1'b0;
      fwd_vld_d = 1'b0;
    end
    if (in_accept) begin
      s1_vld_d  = 1'b1;
      fwd_vld_d = s1_wr && (s1_addr_q == in_addr);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_delay_q <= ktar_pkg::InitialDelayReset;
      rep_period_q <= ktar_pkg::RepeatPeriodReset;
      clr_busy_q   <= 1'b1;
      clr_cnt_q    <= '0;
      s1_vld_q     <= 1'b0;
      fwd_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      init_delay_q <= init_delay_d;
      rep_period_q <= rep_period_d;
      clr_busy_q   <= clr_busy_d;
      clr_cnt_q    <= clr_cnt_d;
      s1_vld_q     <= s1_vld_d;
      fwd_vld_q    <= fwd_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_range_q   <= in_range;
      s1_addr_q    <= in_addr;
      s1_pressed_q <= in_pressed;
      s1_rep_en_q  <= in_rep_en;
      s1_now_q     <= in_now;
      fwd_entry_q  <= new_entry;
    end
    if (s1_adv) begin
      out_tap_q <= new_tap;
    end
  end

  // key state memory
  ktar_ram #(
    .WIDTH (ktar_pkg::EntryW),
    .DEPTH (KEY_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(ktar_pkg::OutDataW - 1){1'b0}}, out_tap_q};

  // checks
  `KTAR_ASSERT(a_no_accept_in_clear, !(clr_busy_q && s_axis_tready_o), "query taken during clear")
  `KTAR_ASSERT(a_clear_blocks_stage, clr_busy_q |-> !s1_vld_q, "stage busy during clear")
  `KTAR_ASSERT(a_fwd_has_stage, fwd_vld_q |-> s1_vld_q, "forwarded entry without a query")
  `KTAR_ASSERT(a_accept_fills_stage, in_accept |=> s1_vld_q, "accepted query lost")
  `KTAR_ASSERT(a_range_no_write, (s1_vld_q && !s1_range_q) |-> !ram_we, "out of range key written")

endmodule

`default_nettype wire
